[rtl/core/lrupr_pkg.sv]
// Shared constants for the LRU page replacement table.
`default_nettype none

package lrupr_pkg;

   // parameter defaults
   localparam int FRAMES_DEF    = 16;
   localparam int PAGE_BITS_DEF = 16;

   // word field widths
   localparam int PAGE_W  = 16;
   localparam int SLOT_W  = 4;
   localparam int TOTAL_W = 32;
   localparam int AF_W    = 5;

   // active frame register reset value
   localparam logic [AF_W-1:0] AF_RESET = 5'd16;

   // stream word widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_USED_W = 1 + SLOT_W + 1 + PAGE_W + TOTAL_W + TOTAL_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

endpackage

`default_nettype wire

[rtl/core/lru_page_replacement.sv]
// Fully associative LRU page frame table built around one frame memory.
`default_nettype none

// Channel   Direction  Word contents (low bit first)
// req_*     in         page_number[15:0]
// rsp_*     out        hit, frame_slot[3:0], evicted, evicted_page[15:0],
//                      hit_total[31:0], fault_total[31:0], zero pad[1:0]
// csr_*     in         active_frames[4:0]
//
// One reference at a time. The single read port of the frame memory sets the
// pace, one entry per cycle for the search pass over the active frames and
// again for the recency update pass. Reset is synchronous and clears the
// valid bits, counters and control; the frame memory itself is not cleared.
// A finished word sits in the output register while the next reference is
// taken; a stalled rsp_tready holds only the final load of the next word.

module lru_page_replacement #(
   parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lrupr_pkg::REQ_DATA_W-1:0]  req_tdata,   // page_number
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit, frame_slot, evicted, evicted_page, hit_total, fault_total, pad
   output logic [lrupr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lrupr_pkg::AF_W-1:0]        csr_data     // active_frames
);
   import lrupr_pkg::*;

   localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int FCNT_W = $clog2(FRAMES + 1);
   localparam int RW     = FIDX_W;
   localparam int MW     = PAGE_BITS + RW;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_UPDATE = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic [AF_W-1:0]           af_ff;
   logic [FCNT_W-1:0]         ptr_ff, ptr_in;
   logic [FCNT_W-1:0]         nact, limit;
   logic                      issue, scan_done, out_free;

   // frame memory: {page, rank} per row
   logic [MW-1:0]             frame_mem [FRAMES];
   logic [MW-1:0]             rd_row_ff;
   logic [FIDX_W-1:0]         rd_idx_ff;
   logic                      rd_vld_ff;
   logic [FIDX_W-1:0]         rd_addr;
   logic [PAGE_BITS-1:0]      rd_page;
   logic [RW-1:0]             rd_rank;
   logic                      rd_valid;
   logic                      mem_we;
   logic [FIDX_W-1:0]         mem_wa;
   logic [MW-1:0]             mem_wd;

   // per-reference working registers
   logic [PAGE_BITS-1:0]      page_ff;
   logic [FCNT_W-1:0]         nact_ff;
   logic                      found_ff, empty_ff;
   logic [FIDX_W-1:0]         match_idx_ff, empty_idx_ff, best_idx_ff;
   logic [RW-1:0]             match_rank_ff, best_rank_ff;
   logic [PAGE_BITS-1:0]      best_page_ff;
   logic                      hit_ff, ev_ff;
   logic [FIDX_W-1:0]         slot_ff;
   logic [RW-1:0]             tgt_rank_ff;
   logic [PAGE_BITS-1:0]      evp_ff;

   // table state held in flops
   logic [FRAMES-1:0]         valid_ff;
   logic [FCNT_W-1:0]         vcnt_ff;
   logic [TOTAL_W-1:0]        hit_cnt_ff, fault_cnt_ff;
   logic [TOTAL_W-1:0]        hit_cnt_in, fault_cnt_in;

   logic                      rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // effective frame count: zero acts as one, clipped to FRAMES
   always_comb begin
      if (af_ff == '0) begin
         nact = FCNT_W'(1);
      end else if (int'(af_ff) > FRAMES) begin
         nact = FCNT_W'(FRAMES);
      end else begin
         nact = FCNT_W'(af_ff);
      end
   end

   // read pipeline shared by the search and update passes
   assign limit     = (state_ff == S_SCAN) ? nact_ff : FCNT_W'(FRAMES);
   assign issue     = ((state_ff == S_SCAN) || (state_ff == S_UPDATE)) && (ptr_ff < limit);
   assign scan_done = !issue && !rd_vld_ff;
   assign rd_addr   = ptr_ff[FIDX_W-1:0];
   assign rd_valid  = valid_ff[rd_idx_ff];
   assign rd_page   = rd_row_ff[MW-1:RW];
   assign rd_rank   = rd_valid ? rd_row_ff[RW-1:0] : '0;

   // write port: fill of an empty frame, or recency rewrite during update
   always_comb begin
      mem_we = 1'b0;
      mem_wa = rd_idx_ff;
      mem_wd = rd_row_ff;
      if ((state_ff == S_DECIDE) && !found_ff && empty_ff) begin
         mem_we = 1'b1;
         mem_wa = empty_idx_ff;
         mem_wd = {page_ff, RW'(vcnt_ff)};
      end else if ((state_ff == S_UPDATE) && rd_vld_ff) begin
         if (rd_idx_ff == slot_ff) begin
            mem_we = 1'b1;
            mem_wd = {page_ff, RW'(vcnt_ff - FCNT_W'(1))};
         end else if (rd_valid && (rd_rank > tgt_rank_ff)) begin
            mem_we = 1'b1;
            mem_wd = {rd_page, rd_rank - RW'(1)};
         end
      end
   end

   // frame memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wa] <= mem_wd;
      end
      if (issue) begin
         rd_row_ff <= frame_mem[rd_addr];
      end
      rd_idx_ff <= rd_addr;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      if (issue) begin
         ptr_in = ptr_ff + FCNT_W'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_SCAN;
               ptr_in   = '0;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            ptr_in   = '0;
            state_in = (found_ff || !empty_ff) ? S_UPDATE : S_RESP;
         end
         S_UPDATE: begin
            if (scan_done) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // saturating totals
   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      if (hit_ff) begin
         if (hit_cnt_ff != '1) begin
            hit_cnt_in = hit_cnt_ff + TOTAL_W'(1);
         end
      end else begin
         if (fault_cnt_ff != '1) begin
            fault_cnt_in = fault_cnt_ff + TOTAL_W'(1);
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ptr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         af_ff         <= AF_RESET;
         valid_ff      <= '0;
         vcnt_ff       <= '0;
         hit_cnt_ff    <= '0;
         fault_cnt_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         rd_vld_ff <= issue;
         if (csr_valid) begin
            af_ff <= csr_data;
         end
         // fill of an empty frame
         if ((state_ff == S_DECIDE) && !found_ff && empty_ff) begin
            valid_ff[empty_idx_ff] <= 1'b1;
            vcnt_ff                <= vcnt_ff + FCNT_W'(1);
         end
         if ((state_ff == S_RESP) && out_free) begin
            hit_cnt_ff    <= hit_cnt_in;
            fault_cnt_ff  <= fault_cnt_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // working registers and output word
   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_tvalid) begin
         page_ff  <= PAGE_BITS'(req_tdata[PAGE_W-1:0]);
         nact_ff  <= nact;
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
      end
      // search pass: first match, first empty, oldest rank
      if ((state_ff == S_SCAN) && rd_vld_ff) begin
         if (!found_ff && rd_valid && (rd_page == page_ff)) begin
            found_ff      <= 1'b1;
            match_idx_ff  <= rd_idx_ff;
            match_rank_ff <= rd_rank;
         end
         if (!empty_ff && !rd_valid) begin
            empty_ff     <= 1'b1;
            empty_idx_ff <= rd_idx_ff;
         end
         if ((rd_idx_ff == '0) || (rd_rank < best_rank_ff)) begin
            best_rank_ff <= rd_rank;
            best_idx_ff  <= rd_idx_ff;
            best_page_ff <= rd_page;
         end
      end
      // outcome
      if (state_ff == S_DECIDE) begin
         if (found_ff) begin
            hit_ff      <= 1'b1;
            ev_ff       <= 1'b0;
            slot_ff     <= match_idx_ff;
            tgt_rank_ff <= match_rank_ff;
            evp_ff      <= '0;
         end else if (empty_ff) begin
            hit_ff      <= 1'b0;
            ev_ff       <= 1'b0;
            slot_ff     <= empty_idx_ff;
            tgt_rank_ff <= '0;
            evp_ff      <= '0;
         end else begin
            hit_ff      <= 1'b0;
            ev_ff       <= 1'b1;
            slot_ff     <= best_idx_ff;
            tgt_rank_ff <= best_rank_ff;
            evp_ff      <= best_page_ff;
         end
      end
      if ((state_ff == S_RESP) && out_free) begin
         rsp_tdata_ff <= {{RSP_PAD_W{1'b0}}, fault_cnt_in, hit_cnt_in,
                          PAGE_W'(evp_ff), ev_ff, SLOT_W'(slot_ff), hit_ff};
      end
   end

`ifndef SYNTHESIS
   // valid count tracks the valid bits
   a_vcnt: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(vcnt_ff))
      else $error("valid count out of step with valid bits");

   // memory writes only on fill or update
   a_we: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_DECIDE) || (state_ff == S_UPDATE)))
      else $error("frame memory written outside fill or update");

   // eviction only when every active frame is full
   a_evict: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DECIDE) && !found_ff && !empty_ff) |-> (vcnt_ff >= nact_ff))
      else $error("eviction with an empty active frame");
`endif

endmodule

`default_nettype wire

[dv/lru_checker.sv]
// Scoreboard for the LRU page table: predicts every lookup and checks each response word.
`timescale 1ns / 1ps

module lru_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [lrupr_pkg::REQ_DATA_W-1:0] req_tdata,   // page_number
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // hit, frame_slot, evicted, evicted_page, hit_total, fault_total, pad
   input  logic [lrupr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [lrupr_pkg::AF_W-1:0]       csr_data,    // active_frames
   output int                               fail_count,
   output int                               open_count
);
   import lrupr_pkg::*;

   // response word layout, hit in bit 0
   typedef struct packed {
      logic [TOTAL_W-1:0] fault_total;
      logic [TOTAL_W-1:0] hit_total;
      logic [PAGE_W-1:0]  evicted_page;
      logic               evicted;
      logic [SLOT_W-1:0]  frame_slot;
      logic               hit;
   } lookup_result_type;

   // shadow copy of the frame table
   logic [PAGE_W-1:0]  frame_page [FRAMES_DEF];
   bit                 frame_used [FRAMES_DEF];
   int                 frame_age  [FRAMES_DEF];
   logic [TOTAL_W-1:0] hits;
   logic [TOTAL_W-1:0] faults;
   logic [AF_W-1:0]    frame_limit;

   lookup_result_type pending_lookups [$];
   int mismatch_total = 0;
   int words_open     = 0;
   int rsp_index      = 0;

   assign fail_count = mismatch_total;
   assign open_count = words_open;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: rsp word %0d %s: got 0x%0h, expected 0x%0h",
               $time, rsp_index, what, got, want);
      mismatch_total++;
   endtask

   function automatic int resident_count();
      int v;
      v = 0;
      for (int i = 0; i < FRAMES_DEF; i++)
         if (frame_used[i]) v++;
      return v;
   endfunction

   function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] x);
      return (x == '1) ? x : x + TOTAL_W'(1);
   endfunction

   // make frame f the most recently used one
   task automatic promote(input int f);
      int r;
      r = frame_age[f];
      for (int i = 0; i < FRAMES_DEF; i++)
         if (frame_used[i] && frame_age[i] > r) frame_age[i]--;
      frame_age[f] = resident_count() - 1;
   endtask

   task automatic predict_lookup(input logic [PAGE_W-1:0] page,
                                 output lookup_result_type res);
      int  limit;
      int  slot;
      int  best;
      bit  found;
      bit  empty;
      limit = (frame_limit == 0) ? 1 :
              ((int'(frame_limit) > FRAMES_DEF) ? FRAMES_DEF : int'(frame_limit));
      slot  = 0;
      found = 0;
      empty = 0;
      res   = '0;
      // lowest-indexed active match wins
      for (int i = 0; i < limit; i++)
         if (!found && frame_used[i] && frame_page[i] == page) begin
            slot  = i;
            found = 1;
         end
      if (found) begin
         promote(slot);
         hits = bump(hits);
      end else begin
         for (int i = 0; i < limit; i++)
            if (!empty && !frame_used[i]) begin
               slot  = i;
               empty = 1;
            end
         if (empty) begin
            frame_age[slot]  = resident_count();
            frame_used[slot] = 1;
            frame_page[slot] = page;
         end else begin
            // oldest active frame goes, lowest index on a tie
            best = 0;
            for (int i = 1; i < limit; i++)
               if (frame_age[i] < frame_age[best]) best = i;
            slot             = best;
            res.evicted      = 1'b1;
            res.evicted_page = frame_page[slot];
            frame_page[slot] = page;
            promote(slot);
         end
         faults = bump(faults);
      end
      res.hit         = found;
      res.frame_slot  = slot[SLOT_W-1:0];
      res.hit_total   = hits;
      res.fault_total = faults;
   endtask

   // sample the channels on each edge, pre-edge values
   always @(posedge clock) begin
      lookup_result_type got;
      lookup_result_type want;
      if (reset) begin
         for (int i = 0; i < FRAMES_DEF; i++) begin
            frame_page[i] = '0;
            frame_used[i] = 0;
            frame_age[i]  = 0;
         end
         hits        = '0;
         faults      = '0;
         frame_limit = AF_RESET;
         pending_lookups.delete();
      end else begin
         if (csr_valid && csr_ready) frame_limit = csr_data;
         // compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = lookup_result_type'(rsp_tdata[RSP_USED_W-1:0]);
            if (pending_lookups.size() == 0) begin
               report_mismatch("word with no lookup pending", 32'(got.frame_slot), 0);
            end else begin
               want = pending_lookups.pop_front();
               if (got.hit !== want.hit)
                  report_mismatch("hit", 32'(got.hit), 32'(want.hit));
               if (got.frame_slot !== want.frame_slot)
                  report_mismatch("frame_slot", 32'(got.frame_slot),
                                  32'(want.frame_slot));
               if (got.evicted !== want.evicted)
                  report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
               if (got.evicted_page !== want.evicted_page)
                  report_mismatch("evicted_page", 32'(got.evicted_page),
                                  32'(want.evicted_page));
               if (got.hit_total !== want.hit_total)
                  report_mismatch("hit_total", got.hit_total, want.hit_total);
               if (got.fault_total !== want.fault_total)
                  report_mismatch("fault_total", got.fault_total, want.fault_total);
            end
            rsp_index++;
         end
         if (req_tvalid && req_tready) begin
            predict_lookup(req_tdata[PAGE_W-1:0], want);
            pending_lookups.push_back(want);
         end
      end
      words_open <= pending_lookups.size();
   end

endmodule

[dv/tb_top.sv]
// Testbench top for the LRU page table: reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_top;
   import lrupr_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [AF_W-1:0]       csr_data   = '0;
   logic                  steady     = 1'b0;
   int                    fail_count;
   int                    open_count;

   lru_page_replacement DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   lru_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver stalls about 17 percent of cycles outside the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 17);
   end

   // one page reference word, with an occasional gap ahead of it
   task automatic send_page(input logic [PAGE_W-1:0] page);
      if (!steady && $urandom_range(0, 99) < 17) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold the sender until every predicted word has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // frame count changes only on an idle table
   task automatic set_frames(input logic [AF_W-1:0] count);
      drain();
      repeat (50) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [AF_W-1:0]   phase_frames [9];
      logic [PAGE_W-1:0] pool [$];
      int                n_eff;
      int                pick;

      phase_frames    = '{5'd1, 5'd8, 5'd16, 5'd3, 5'd31, 5'd0, 5'd12, 5'd2, 5'd7};
      phase_frames[8] = AF_W'($urandom_range(0, 31));
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: fill all 16 frames at the reset frame count, with a hit in between
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      for (int k = 1; k <= 14; k++) send_page(PAGE_W'(k * 16'h1111));
      // table full: oldest frame gets evicted
      send_page(16'h8000);
      // shrink: a page resident above the limit misses and ends up twice
      set_frames(5'd4);
      send_page(16'hAAAA);
      set_frames(5'd16);
      send_page(16'hAAAA);
      // zero frames acts as one
      set_frames(5'd0);
      send_page(16'h5A5A);
      send_page(16'h5A5A);
      // too many frames acts as the full table
      set_frames(5'd31);
      send_page(16'hAAAA);
      send_page(16'h1234);

      // random phases, mostly drawn from a working set near the frame count
      for (int ph = 0; ph < 9; ph++) begin
         set_frames(phase_frames[ph]);
         steady <= (ph == 2);
         n_eff = (phase_frames[ph] == 0) ? 1 :
                 ((int'(phase_frames[ph]) > FRAMES_DEF) ? FRAMES_DEF :
                  int'(phase_frames[ph]));
         pool.delete();
         repeat (n_eff + $urandom_range(1, 4))
            pool.push_back(PAGE_W'($urandom_range(0, 65535)));
         for (int j = 0; j < 56; j++) begin
            if (ph == 1 && j == 28) drain();
            pick = $urandom_range(0, 99);
            if (pick < 75) send_page(pool[$urandom_range(0, pool.size() - 1)]);
            else if (pick < 95) send_page(PAGE_W'($urandom_range(0, 65535)));
            else send_page(pick[0] ? 16'hFFFF : 16'h0000);
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
